// ===== rtl/core/cpec_pkg.sv =====
// ---------------------------------------------------------------------------
// cpec_pkg
// Shared widths, body record and saturation for the circle pair collision unit.
// ---------------------------------------------------------------------------
package cpec_pkg;

    localparam int FIELD_W = 24;
    localparam int RAD_W   = 16;
    localparam int DIFF_W  = 25;
    localparam int RSUM_W  = 17;
    localparam int NEAR_W  = 18;
    localparam int D2_W    = 50;
    localparam int RR_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int QP_W    = 43;
    localparam int Q_W     = 44;
    localparam int PUSH_W  = 35;
    localparam int M_W     = 62;
    localparam int G_W     = 46;
    localparam int VM_W    = 64;
    localparam int DV_W    = 48;
    localparam int S_W     = 20;
    localparam int SUM_W   = 49;

    localparam int FIELD_MAX = 8388607;
    localparam int FIELD_MIN = -8388608;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] vx;
        logic signed [FIELD_W-1:0] vy;
    } body_t;

    function automatic logic signed [FIELD_W-1:0] sat_field(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(FIELD_MAX);
        lo = SUM_W'(FIELD_MIN);
        if (v > hi)
        begin
            return hi[FIELD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[FIELD_W-1:0];
        end
        return v[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/circle_pair_elastic_collision_unit.sv =====
// ---------------------------------------------------------------------------
// circle_pair_elastic_collision_unit
// Overlap test, push-apart and elastic normal velocity exchange for a pair.
// ---------------------------------------------------------------------------
// A pair transfers on any cycle that start is high; busy stays low, so one
// pair may enter every cycle. Each result shows on done for one cycle, in
// input order, after its pair has passed through the chain of bit-per-stage
// units: the square root (18 stages), the push divide (38), the normal
// impulse divide (65) and the velocity divide (67), plus six stages of
// difference, product and output logic.
module circle_pair_elastic_collision_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [23:0] first_x,
    input  logic signed [23:0] first_y,
    input  logic signed [23:0] first_vx,
    input  logic signed [23:0] first_vy,
    input  logic [15:0] first_radius,
    input  logic signed [23:0] second_x,
    input  logic signed [23:0] second_y,
    input  logic signed [23:0] second_vx,
    input  logic signed [23:0] second_vy,
    input  logic [15:0] second_radius,
    output logic        done,
    output logic signed [23:0] new_first_x,
    output logic signed [23:0] new_first_y,
    output logic signed [23:0] new_first_vx,
    output logic signed [23:0] new_first_vy,
    output logic signed [23:0] new_second_x,
    output logic signed [23:0] new_second_y,
    output logic signed [23:0] new_second_vx,
    output logic signed [23:0] new_second_vy,
    output logic        hit
);

    typedef struct packed {
        logic                                  hit;
        logic signed [cpec_pkg::NEAR_W-1:0]    dx;
        logic signed [cpec_pkg::NEAR_W-1:0]    dy;
        logic signed [cpec_pkg::Q_W-1:0]       q;
        logic [cpec_pkg::RSUM_W-1:0]           rs;
        logic [cpec_pkg::RAD_W-1:0]            r1;
        logic [cpec_pkg::RAD_W-1:0]            r2;
        logic [cpec_pkg::RR_W-1:0]             d2;
        cpec_pkg::body_t                       b1;
        cpec_pkg::body_t                       b2;
    } sq_pay_t;

    typedef struct packed {
        logic                                  hit;
        logic signed [cpec_pkg::NEAR_W-1:0]    dx;
        logic signed [cpec_pkg::NEAR_W-1:0]    dy;
        logic [cpec_pkg::RR_W-1:0]             d2;
        logic [cpec_pkg::RSUM_W-1:0]           rs;
        logic signed [cpec_pkg::M_W-1:0]       m1;
        logic signed [cpec_pkg::M_W-1:0]       m2;
        cpec_pkg::body_t                       b1;
        cpec_pkg::body_t                       b2;
    } sx_pay_t;

    typedef struct packed {
        logic                                  hit;
        logic signed [cpec_pkg::NEAR_W-1:0]    dx;
        logic signed [cpec_pkg::NEAR_W-1:0]    dy;
        logic [cpec_pkg::RR_W-1:0]             d2;
        logic signed [cpec_pkg::S_W-1:0]       sx;
        logic signed [cpec_pkg::S_W-1:0]       sy;
        cpec_pkg::body_t                       b1;
        cpec_pkg::body_t                       b2;
    } g_pay_t;

    typedef struct packed {
        logic                                  hit;
        logic signed [cpec_pkg::S_W-1:0]       sx;
        logic signed [cpec_pkg::S_W-1:0]       sy;
        cpec_pkg::body_t                       b1;
        cpec_pkg::body_t                       b2;
    } v_pay_t;

    localparam int SXQ_W = cpec_pkg::PUSH_W + 3;
    localparam int GQ_W  = cpec_pkg::M_W + 3;
    localparam int VQ_W  = cpec_pkg::VM_W + 3;

    // stage 1: differences
    logic                                   a1_vld_reg;
    logic signed [cpec_pkg::DIFF_W-1:0]     a1_dx_reg, a1_dy_reg, a1_dvx_reg, a1_dvy_reg;
    logic [cpec_pkg::RSUM_W-1:0]            a1_rs_reg;
    logic [cpec_pkg::RAD_W-1:0]             a1_r1_reg, a1_r2_reg;
    cpec_pkg::body_t                        a1_b1_reg, a1_b2_reg;

    // stage 2: products
    logic                                   a2_vld_reg;
    logic signed [cpec_pkg::D2_W-1:0]       a2_dxx_reg, a2_dyy_reg;
    logic [cpec_pkg::RR_W-1:0]              a2_rr_reg;
    logic signed [cpec_pkg::QP_W-1:0]       a2_qx_reg, a2_qy_reg;
    logic signed [cpec_pkg::NEAR_W-1:0]     a2_dx_reg, a2_dy_reg;
    logic [cpec_pkg::RSUM_W-1:0]            a2_rs_reg;
    logic [cpec_pkg::RAD_W-1:0]             a2_r1_reg, a2_r2_reg;
    cpec_pkg::body_t                        a2_b1_reg, a2_b2_reg;

    // stage 3: sums and overlap test
    logic                                   a3_vld_reg;
    logic [cpec_pkg::D2_W-1:0]              a3_d2_next;
    logic [cpec_pkg::RR_W-1:0]              a3_d2_reg;
    sq_pay_t                                a3_pay_reg;

    logic                                   sq_vld;
    logic [cpec_pkg::ROOT_W-1:0]            sq_root;
    sq_pay_t                                sq_pay;

    // stage 4: push numerators and impulse numerators
    logic [cpec_pkg::RSUM_W-1:0]            pen;
    logic signed [18:0]                     twice_r2;
    logic signed [18:0]                     twice_r1_neg;
    logic                                   a4_vld_reg;
    logic signed [cpec_pkg::PUSH_W-1:0]     a4_px_reg, a4_py_reg;
    logic [cpec_pkg::NEAR_W-1:0]            a4_den_reg;
    sx_pay_t                                a4_pay_reg;

    logic                                   sx_vld, sy_vld;
    logic signed [SXQ_W-1:0]                sx_quo, sy_quo;
    sx_pay_t                                sx_pay;
    g_pay_t                                 g_pay_in;

    logic                                   g1_vld, g2_vld;
    logic signed [GQ_W-1:0]                 g1_quo, g2_quo;
    g_pay_t                                 g_pay;
    logic signed [cpec_pkg::G_W-1:0]        g1, g2;

    // stage 5: velocity numerators
    logic                                   a5_vld_reg;
    logic signed [cpec_pkg::VM_W-1:0]       a5_mx1_reg, a5_my1_reg, a5_mx2_reg, a5_my2_reg;
    logic [cpec_pkg::RR_W-1:0]              a5_d2_reg;
    v_pay_t                                 a5_pay_reg;

    logic                                   va_vld;
    logic signed [VQ_W-1:0]                 va_quo, vb_quo, vc_quo, vd_quo;
    v_pay_t                                 v_pay;
    logic signed [cpec_pkg::DV_W-1:0]       dvx1, dvy1, dvx2, dvy2;

    // output stage
    logic                                   done_reg;
    logic                                   hit_reg;
    cpec_pkg::body_t                        o_b1_reg, o_b2_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
            a3_vld_reg <= 1'b0;
            a4_vld_reg <= 1'b0;
            a5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a1_vld_reg <= start && !busy;
            a2_vld_reg <= a1_vld_reg;
            a3_vld_reg <= a2_vld_reg;
            a4_vld_reg <= sq_vld;
            a5_vld_reg <= g1_vld;
            done_reg   <= va_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_dx_reg  <= cpec_pkg::DIFF_W'(first_x) - cpec_pkg::DIFF_W'(second_x);
        a1_dy_reg  <= cpec_pkg::DIFF_W'(first_y) - cpec_pkg::DIFF_W'(second_y);
        a1_dvx_reg <= cpec_pkg::DIFF_W'(second_vx) - cpec_pkg::DIFF_W'(first_vx);
        a1_dvy_reg <= cpec_pkg::DIFF_W'(second_vy) - cpec_pkg::DIFF_W'(first_vy);
        a1_rs_reg  <= {1'b0, first_radius} + {1'b0, second_radius};
        a1_r1_reg  <= first_radius;
        a1_r2_reg  <= second_radius;
        a1_b1_reg  <= '{x: first_x, y: first_y, vx: first_vx, vy: first_vy};
        a1_b2_reg  <= '{x: second_x, y: second_y, vx: second_vx, vy: second_vy};
    end

    always_ff @(posedge clk)
    begin
        a2_dxx_reg <= a1_dx_reg * a1_dx_reg;
        a2_dyy_reg <= a1_dy_reg * a1_dy_reg;
        a2_rr_reg  <= a1_rs_reg * a1_rs_reg;
        a2_qx_reg  <= a1_dvx_reg * $signed(a1_dx_reg[cpec_pkg::NEAR_W-1:0]);
        a2_qy_reg  <= a1_dvy_reg * $signed(a1_dy_reg[cpec_pkg::NEAR_W-1:0]);
        a2_dx_reg  <= a1_dx_reg[cpec_pkg::NEAR_W-1:0];
        a2_dy_reg  <= a1_dy_reg[cpec_pkg::NEAR_W-1:0];
        a2_rs_reg  <= a1_rs_reg;
        a2_r1_reg  <= a1_r1_reg;
        a2_r2_reg  <= a1_r2_reg;
        a2_b1_reg  <= a1_b1_reg;
        a2_b2_reg  <= a1_b2_reg;
    end

    assign a3_d2_next = $unsigned(a2_dxx_reg) + $unsigned(a2_dyy_reg);

    always_ff @(posedge clk)
    begin
        a3_d2_reg      <= a3_d2_next[cpec_pkg::RR_W-1:0];
        a3_pay_reg.hit <= (a3_d2_next != '0)
                       && (a3_d2_next < {{(cpec_pkg::D2_W-cpec_pkg::RR_W){1'b0}}, a2_rr_reg});
        a3_pay_reg.dx  <= a2_dx_reg;
        a3_pay_reg.dy  <= a2_dy_reg;
        a3_pay_reg.q   <= cpec_pkg::Q_W'(a2_qx_reg) + cpec_pkg::Q_W'(a2_qy_reg);
        a3_pay_reg.rs  <= a2_rs_reg;
        a3_pay_reg.r1  <= a2_r1_reg;
        a3_pay_reg.r2  <= a2_r2_reg;
        a3_pay_reg.d2  <= a3_d2_next[cpec_pkg::RR_W-1:0];
        a3_pay_reg.b1  <= a2_b1_reg;
        a3_pay_reg.b2  <= a2_b2_reg;
    end

    cpec_isqrt #(
        .ROOT_W (cpec_pkg::ROOT_W),
        .PAY_W  ($bits(sq_pay_t))
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a3_vld_reg),
        .rad     (a3_d2_reg),
        .in_pay  (a3_pay_reg),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_pay (sq_pay)
    );

    assign pen          = sq_pay.rs - sq_root;
    assign twice_r2     = $signed({2'b00, sq_pay.r2, 1'b0});
    assign twice_r1_neg = -$signed({2'b00, sq_pay.r1, 1'b0});

    always_ff @(posedge clk)
    begin
        a4_px_reg      <= sq_pay.dx * $signed({1'b0, pen});
        a4_py_reg      <= sq_pay.dy * $signed({1'b0, pen});
        a4_den_reg     <= {sq_root, 1'b0};
        a4_pay_reg.hit <= sq_pay.hit;
        a4_pay_reg.dx  <= sq_pay.dx;
        a4_pay_reg.dy  <= sq_pay.dy;
        a4_pay_reg.d2  <= sq_pay.d2;
        a4_pay_reg.rs  <= sq_pay.rs;
        a4_pay_reg.m1  <= sq_pay.q * twice_r2;
        a4_pay_reg.m2  <= sq_pay.q * twice_r1_neg;
        a4_pay_reg.b1  <= sq_pay.b1;
        a4_pay_reg.b2  <= sq_pay.b2;
    end

    cpec_rdiv #(
        .NUM_W (cpec_pkg::PUSH_W),
        .DEN_W (cpec_pkg::NEAR_W),
        .PAY_W ($bits(sx_pay_t))
    ) u_push_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a4_vld_reg),
        .num     (a4_px_reg),
        .den     (a4_den_reg),
        .in_pay  (a4_pay_reg),
        .out_vld (sx_vld),
        .quo     (sx_quo),
        .out_pay (sx_pay)
    );

    cpec_rdiv #(
        .NUM_W (cpec_pkg::PUSH_W),
        .DEN_W (cpec_pkg::NEAR_W),
        .PAY_W (1)
    ) u_push_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a4_vld_reg),
        .num     (a4_py_reg),
        .den     (a4_den_reg),
        .in_pay  (1'b0),
        .out_vld (sy_vld),
        .quo     (sy_quo),
        .out_pay ()
    );

    assign g_pay_in.hit = sx_pay.hit;
    assign g_pay_in.dx  = sx_pay.dx;
    assign g_pay_in.dy  = sx_pay.dy;
    assign g_pay_in.d2  = sx_pay.d2;
    assign g_pay_in.sx  = sx_quo[cpec_pkg::S_W-1:0];
    assign g_pay_in.sy  = sy_quo[cpec_pkg::S_W-1:0];
    assign g_pay_in.b1  = sx_pay.b1;
    assign g_pay_in.b2  = sx_pay.b2;

    cpec_rdiv #(
        .NUM_W (cpec_pkg::M_W),
        .DEN_W (cpec_pkg::RSUM_W),
        .PAY_W ($bits(g_pay_t))
    ) u_impulse_1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sx_vld),
        .num     (sx_pay.m1),
        .den     (sx_pay.rs),
        .in_pay  (g_pay_in),
        .out_vld (g1_vld),
        .quo     (g1_quo),
        .out_pay (g_pay)
    );

    cpec_rdiv #(
        .NUM_W (cpec_pkg::M_W),
        .DEN_W (cpec_pkg::RSUM_W),
        .PAY_W (1)
    ) u_impulse_2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sx_vld),
        .num     (sx_pay.m2),
        .den     (sx_pay.rs),
        .in_pay  (1'b0),
        .out_vld (g2_vld),
        .quo     (g2_quo),
        .out_pay ()
    );

    assign g1 = g1_quo[cpec_pkg::G_W-1:0];
    assign g2 = g2_quo[cpec_pkg::G_W-1:0];

    always_ff @(posedge clk)
    begin
        a5_mx1_reg     <= g_pay.dx * g1;
        a5_my1_reg     <= g_pay.dy * g1;
        a5_mx2_reg     <= g_pay.dx * g2;
        a5_my2_reg     <= g_pay.dy * g2;
        a5_d2_reg      <= g_pay.d2;
        a5_pay_reg.hit <= g_pay.hit;
        a5_pay_reg.sx  <= g_pay.sx;
        a5_pay_reg.sy  <= g_pay.sy;
        a5_pay_reg.b1  <= g_pay.b1;
        a5_pay_reg.b2  <= g_pay.b2;
    end

    cpec_rdiv #(
        .NUM_W (cpec_pkg::VM_W),
        .DEN_W (cpec_pkg::RR_W),
        .PAY_W ($bits(v_pay_t))
    ) u_vel_x1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a5_vld_reg),
        .num     (a5_mx1_reg),
        .den     (a5_d2_reg),
        .in_pay  (a5_pay_reg),
        .out_vld (va_vld),
        .quo     (va_quo),
        .out_pay (v_pay)
    );

    cpec_rdiv #(
        .NUM_W (cpec_pkg::VM_W),
        .DEN_W (cpec_pkg::RR_W),
        .PAY_W (1)
    ) u_vel_y1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a5_vld_reg),
        .num     (a5_my1_reg),
        .den     (a5_d2_reg),
        .in_pay  (1'b0),
        .out_vld (),
        .quo     (vb_quo),
        .out_pay ()
    );

    cpec_rdiv #(
        .NUM_W (cpec_pkg::VM_W),
        .DEN_W (cpec_pkg::RR_W),
        .PAY_W (1)
    ) u_vel_x2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a5_vld_reg),
        .num     (a5_mx2_reg),
        .den     (a5_d2_reg),
        .in_pay  (1'b0),
        .out_vld (),
        .quo     (vc_quo),
        .out_pay ()
    );

    cpec_rdiv #(
        .NUM_W (cpec_pkg::VM_W),
        .DEN_W (cpec_pkg::RR_W),
        .PAY_W (1)
    ) u_vel_y2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (a5_vld_reg),
        .num     (a5_my2_reg),
        .den     (a5_d2_reg),
        .in_pay  (1'b0),
        .out_vld (),
        .quo     (vd_quo),
        .out_pay ()
    );

    assign dvx1 = va_quo[cpec_pkg::DV_W-1:0];
    assign dvy1 = vb_quo[cpec_pkg::DV_W-1:0];
    assign dvx2 = vc_quo[cpec_pkg::DV_W-1:0];
    assign dvy2 = vd_quo[cpec_pkg::DV_W-1:0];

    always_ff @(posedge clk)
    begin
        hit_reg <= v_pay.hit;
        if (v_pay.hit)
        begin
            o_b1_reg.x  <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b1.x)
                                             + cpec_pkg::SUM_W'(v_pay.sx));
            o_b1_reg.y  <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b1.y)
                                             + cpec_pkg::SUM_W'(v_pay.sy));
            o_b1_reg.vx <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b1.vx)
                                             + cpec_pkg::SUM_W'(dvx1));
            o_b1_reg.vy <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b1.vy)
                                             + cpec_pkg::SUM_W'(dvy1));
            o_b2_reg.x  <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b2.x)
                                             - cpec_pkg::SUM_W'(v_pay.sx));
            o_b2_reg.y  <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b2.y)
                                             - cpec_pkg::SUM_W'(v_pay.sy));
            o_b2_reg.vx <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b2.vx)
                                             + cpec_pkg::SUM_W'(dvx2));
            o_b2_reg.vy <= cpec_pkg::sat_field(cpec_pkg::SUM_W'(v_pay.b2.vy)
                                             + cpec_pkg::SUM_W'(dvy2));
        end
        else
        begin
            o_b1_reg <= v_pay.b1;
            o_b2_reg <= v_pay.b2;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign new_first_x   = o_b1_reg.x;
    assign new_first_y   = o_b1_reg.y;
    assign new_first_vx  = o_b1_reg.vx;
    assign new_first_vy  = o_b1_reg.vy;
    assign new_second_x  = o_b2_reg.x;
    assign new_second_y  = o_b2_reg.y;
    assign new_second_vx = o_b2_reg.vx;
    assign new_second_vy = o_b2_reg.vy;

    a_root_below_rsum: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld && sq_pay.hit |-> sq_root < sq_pay.rs)
        else $error("root not below radius sum on a hit");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld && sq_pay.hit |-> sq_root != '0)
        else $error("zero root on a hit");

    a_push_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        sx_vld == sy_vld)
        else $error("push dividers out of step");

    a_impulse_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        g1_vld == g2_vld)
        else $error("impulse dividers out of step");

endmodule

// ===== rtl/core/cpec_isqrt.sv =====
// ---------------------------------------------------------------------------
// cpec_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ---------------------------------------------------------------------------
module cpec_isqrt #(
    parameter int ROOT_W = 17,
    parameter int PAY_W  = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [2*ROOT_W-1:0]   rad,
    input  logic [PAY_W-1:0]      in_pay,
    output logic                  out_vld,
    output logic [ROOT_W-1:0]     root,
    output logic [PAY_W-1:0]      out_pay
);

    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W:0]        vld_reg;
    logic [2*ROOT_W-1:0]    rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]       rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]      root_reg [0:ROOT_W];
    logic [PAY_W-1:0]       pay_reg  [0:ROOT_W];
    logic [REM_W-1:0]       shifted  [0:ROOT_W-1];
    logic [REM_W-1:0]       trial    [0:ROOT_W-1];

    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            shifted[k] = {rem_reg[k][ROOT_W-1:0], rad_reg[k][2*ROOT_W-1 -: 2]};
            trial[k]   = {root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_W-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= rad;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        pay_reg[0]  <= in_pay;
        for (int k = 0; k < ROOT_W; k++)
        begin
            rad_reg[k+1] <= {rad_reg[k][2*ROOT_W-3:0], 2'b00};
            pay_reg[k+1] <= pay_reg[k];
            if (shifted[k] >= trial[k])
            begin
                rem_reg[k+1]  <= shifted[k] - trial[k];
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1]  <= shifted[k];
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W];
    assign root    = root_reg[ROOT_W];
    assign out_pay = pay_reg[ROOT_W];

endmodule

// ===== rtl/core/cpec_rdiv.sv =====
// ---------------------------------------------------------------------------
// cpec_rdiv
// Pipelined signed divide, rounded to nearest with ties away from zero.
// ---------------------------------------------------------------------------
module cpec_rdiv #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 18,
    parameter int PAY_W = 1,
    localparam int ACC_W = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1,
    localparam int QUO_W = ACC_W + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    input  logic [PAY_W-1:0]        in_pay,
    output logic                    out_vld,
    output logic signed [QUO_W-1:0] quo,
    output logic [PAY_W-1:0]        out_pay
);

    localparam int REM_W = DEN_W + 2;

    logic [NUM_W-1:0]  mag;
    logic [ACC_W-1:0]  acc_in;
    logic [ACC_W:0]    vld_reg;
    logic [ACC_W-1:0]  acc_reg [0:ACC_W];
    logic [REM_W-1:0]  rem_reg [0:ACC_W];
    logic [ACC_W-1:0]  quo_reg [0:ACC_W];
    logic [DEN_W:0]    dd_reg  [0:ACC_W];
    logic              neg_reg [0:ACC_W];
    logic [PAY_W-1:0]  pay_reg [0:ACC_W];
    logic [REM_W-1:0]  shifted [0:ACC_W-1];
    logic [REM_W-1:0]  dd_ext  [0:ACC_W-1];

    assign mag    = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
    assign acc_in = {{(ACC_W-NUM_W-1){1'b0}}, mag, 1'b0} + {{(ACC_W-DEN_W){1'b0}}, den};

    always_comb
    begin
        for (int k = 0; k < ACC_W; k++)
        begin
            shifted[k] = {rem_reg[k][REM_W-2:0], acc_reg[k][ACC_W-1]};
            dd_ext[k]  = {1'b0, dd_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ACC_W-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg[0] <= acc_in;
        rem_reg[0] <= '0;
        quo_reg[0] <= '0;
        dd_reg[0]  <= {den, 1'b0};
        neg_reg[0] <= num[NUM_W-1];
        pay_reg[0] <= in_pay;
        for (int k = 0; k < ACC_W; k++)
        begin
            acc_reg[k+1] <= {acc_reg[k][ACC_W-2:0], 1'b0};
            dd_reg[k+1]  <= dd_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            pay_reg[k+1] <= pay_reg[k];
            if (shifted[k] >= dd_ext[k])
            begin
                rem_reg[k+1] <= shifted[k] - dd_ext[k];
                quo_reg[k+1] <= {quo_reg[k][ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= shifted[k];
                quo_reg[k+1] <= {quo_reg[k][ACC_W-2:0], 1'b0};
            end
        end
    end

    assign out_vld = vld_reg[ACC_W];
    assign quo     = neg_reg[ACC_W] ? -$signed({1'b0, quo_reg[ACC_W]})
                                    : $signed({1'b0, quo_reg[ACC_W]});
    assign out_pay = pay_reg[ACC_W];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the circle pair elastic collision unit. A table of
// directed pairs (far, coincident, zero radius, head-on, saturating) is
// followed by random pairs, mostly overlapping, with random gaps in start.
// Every result is compared field by field against a predictor or table row.
// ---------------------------------------------------------------------------
module testbench;

    localparam int FIELD_MAX = cpec_pkg::FIELD_MAX;
    localparam int FIELD_MIN = cpec_pkg::FIELD_MIN;

    typedef struct packed {
        cpec_pkg::body_t a;
        logic [15:0]     ra;
        cpec_pkg::body_t b;
        logic [15:0]     rb;
    } pair_t;

    typedef struct packed {
        cpec_pkg::body_t a;
        cpec_pkg::body_t b;
        logic            hit;
    } outcome_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_UNCHANGED, ROW_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        pair_t     pair;
        outcome_t  typed;
    } row_t;

    localparam int NUM_RANDOM  = 1600;
    localparam int QUIET_ITEMS = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 250;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    pair_t    stim;
    outcome_t res;

    outcome_t resolved_q[$];
    int       errors;
    int       idle_cycles;

    circle_pair_elastic_collision_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_x       (stim.a.x),
        .first_y       (stim.a.y),
        .first_vx      (stim.a.vx),
        .first_vy      (stim.a.vy),
        .first_radius  (stim.ra),
        .second_x      (stim.b.x),
        .second_y      (stim.b.y),
        .second_vx     (stim.b.vx),
        .second_vy     (stim.b.vy),
        .second_radius (stim.rb),
        .done          (done),
        .new_first_x   (res.a.x),
        .new_first_y   (res.a.y),
        .new_first_vx  (res.a.vx),
        .new_first_vy  (res.a.vy),
        .new_second_x  (res.b.x),
        .new_second_y  (res.b.y),
        .new_second_vx (res.b.vx),
        .new_second_vy (res.b.vy),
        .hit           (res.hit)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_div(longint n, longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > FIELD_MAX)
            return 24'sh7FFFFF;
        if (v < FIELD_MIN)
            return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic outcome_t resolve_pair(pair_t p);
        longint x1, y1, vx1, vy1, x2, y2, vx2, vy2;
        longint dx, dy, pen, sx, sy, q, g1, g2;
        longint unsigned d2, r, root_len;
        outcome_t o;
        x1 = p.a.x;  y1 = p.a.y;  vx1 = p.a.vx; vy1 = p.a.vy;
        x2 = p.b.x;  y2 = p.b.y;  vx2 = p.b.vx; vy2 = p.b.vy;
        dx = x1 - x2;
        dy = y1 - y2;
        d2 = dx * dx + dy * dy;
        r = longint'(p.ra) + longint'(p.rb);
        o.hit = (d2 != 0) && (d2 < r * r);
        if (o.hit)
        begin
            root_len = int_sqrt(d2);
            pen = r - root_len;
            sx = round_div(dx * pen, 2 * root_len);
            sy = round_div(dy * pen, 2 * root_len);
            q = (vx2 - vx1) * dx + (vy2 - vy1) * dy;
            g1 = round_div(2 * longint'(p.rb) * q, r);
            g2 = round_div(-2 * longint'(p.ra) * q, r);
            x1 += sx; y1 += sy;
            x2 -= sx; y2 -= sy;
            vx1 += round_div(dx * g1, d2);
            vy1 += round_div(dy * g1, d2);
            vx2 += round_div(dx * g2, d2);
            vy2 += round_div(dy * g2, d2);
        end
        o.a.x = clamp24(x1);  o.a.y = clamp24(y1);
        o.a.vx = clamp24(vx1); o.a.vy = clamp24(vy1);
        o.b.x = clamp24(x2);  o.b.y = clamp24(y2);
        o.b.vx = clamp24(vx2); o.b.vy = clamp24(vy2);
        return o;
    endfunction

    function automatic pair_t mk_pair(int x1, int y1, int vx1, int vy1, int r1,
                                      int x2, int y2, int vx2, int vy2, int r2);
        pair_t p;
        p.a.x = 24'(x1); p.a.y = 24'(y1); p.a.vx = 24'(vx1); p.a.vy = 24'(vy1);
        p.ra = 16'(r1);
        p.b.x = 24'(x2); p.b.y = 24'(y2); p.b.vx = 24'(vx2); p.b.vy = 24'(vy2);
        p.rb = 16'(r2);
        return p;
    endfunction

    function automatic int clamp_int(int v);
        if (v > FIELD_MAX)
            return FIELD_MAX;
        if (v < FIELD_MIN)
            return FIELD_MIN;
        return v;
    endfunction

    function automatic int rand_field();
        return int'($urandom) >>> 8;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int r1, r2, rs, dx, dy, x1, y1;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            return mk_pair(rand_field(), rand_field(), rand_field(), rand_field(),
                           $urandom_range(0, 65535), rand_field(), rand_field(),
                           rand_field(), rand_field(), $urandom_range(0, 65535));
        if (mode < 7)
        begin
            r1 = $urandom_range(1, 4096);
            r2 = $urandom_range(1, 4096);
        end
        else
        begin
            r1 = $urandom_range(1, 65535);
            r2 = $urandom_range(1, 65535);
        end
        rs = r1 + r2;
        dx = $urandom_range(0, 2 * rs) - rs;
        dy = $urandom_range(0, 2 * rs) - rs;
        x1 = rand_field();
        y1 = rand_field();
        if (mode == 9)
        begin
            x1 = ($urandom_range(0, 1) != 0) ? FIELD_MAX - $urandom_range(0, 64)
                                              : FIELD_MIN + $urandom_range(0, 64);
            y1 = ($urandom_range(0, 1) != 0) ? FIELD_MAX : FIELD_MIN;
        end
        p = mk_pair(x1, y1, 0, 0, r1, clamp_int(x1 - dx), clamp_int(y1 - dy),
                    0, 0, r2);
        if (mode == 8)
        begin
            p.a.vx = 24'(rand_field()); p.a.vy = 24'(rand_field());
            p.b.vx = 24'(rand_field()); p.b.vy = 24'(rand_field());
        end
        else
        begin
            p.a.vx = 24'($urandom_range(0, 131072) - 65536);
            p.a.vy = 24'($urandom_range(0, 131072) - 65536);
            p.b.vx = 24'($urandom_range(0, 131072) - 65536);
            p.b.vy = 24'($urandom_range(0, 131072) - 65536);
        end
        return p;
    endfunction

    task automatic transfer_pair(pair_t p, outcome_t exp_out, bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stim  <= p;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        resolved_q = {resolved_q, exp_out};
    endtask

    function automatic void check_field(string name, logic signed [23:0] exp_v,
                                        logic signed [23:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (resolved_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit %0b",
                         $time, res.hit);
                errors++;
            end
            else
            begin
                e = resolved_q.pop_front();
                check_field("new_first_x", e.a.x, res.a.x);
                check_field("new_first_y", e.a.y, res.a.y);
                check_field("new_first_vx", e.a.vx, res.a.vx);
                check_field("new_first_vy", e.a.vy, res.a.vy);
                check_field("new_second_x", e.b.x, res.b.x);
                check_field("new_second_y", e.b.y, res.b.y);
                check_field("new_second_vx", e.b.vx, res.b.vx);
                check_field("new_second_vy", e.b.vy, res.b.vy);
                if (e.hit !== res.hit)
                begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, e.hit, res.hit);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("circle_pair_elastic_collision_unit test failed");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        row_t     row;
        outcome_t o;
        outcome_t typed;

        rst_n = 1'b0;
        start = 1'b0;
        stim  = '0;

        // far apart, extremes of every field
        rows = {rows, row_t'{ROW_UNCHANGED, mk_pair(FIELD_MIN, FIELD_MIN, FIELD_MIN,
            FIELD_MIN, 65535, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, 65535), '0}};
        rows = {rows, row_t'{ROW_UNCHANGED, mk_pair(FIELD_MAX, FIELD_MAX, FIELD_MAX,
            FIELD_MAX, 1, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, 1), '0}};
        // coincident centres
        rows = {rows, row_t'{ROW_UNCHANGED, mk_pair(1000, -2000, 300, 400, 65535,
            1000, -2000, -300, -400, 65535), '0}};
        // both radii zero
        rows = {rows, row_t'{ROW_UNCHANGED,
            mk_pair(0, 0, 5, 5, 0, 1, 0, -5, 0, 0), '0}};
        // exactly touching is no hit
        rows = {rows, row_t'{ROW_UNCHANGED,
            mk_pair(0, 0, 256, 0, 256, 512, 0, 0, 0, 256), '0}};
        // head-on, equal masses: swap velocities and push half overlap each
        typed.a = '{x: -128, y: 0, vx: -256, vy: 0};
        typed.b = '{x: 384, y: 0, vx: 256, vy: 0};
        typed.hit = 1'b1;
        rows = {rows, row_t'{ROW_TYPED,
            mk_pair(0, 0, 256, 0, 256, 256, 0, -256, 0, 256), typed}};
        rows = {rows, row_t'{ROW_PREDICT,
            mk_pair(0, 0, 0, 0, 0, 1, 1, 100, -100, 3), '0}};
        rows = {rows, row_t'{ROW_PREDICT,
            mk_pair(0, 0, 0, 0, 65535, 0, 1, 0, 0, 65535), '0}};
        rows = {rows, row_t'{ROW_PREDICT, mk_pair(FIELD_MAX, FIELD_MAX, FIELD_MAX,
            FIELD_MAX, 65535, FIELD_MAX - 3, FIELD_MAX - 2, FIELD_MIN, FIELD_MIN,
            65535), '0}};
        rows = {rows, row_t'{ROW_PREDICT, mk_pair(FIELD_MIN, FIELD_MIN, FIELD_MIN,
            FIELD_MAX, 40000, FIELD_MIN + 65535, FIELD_MIN + 65535, FIELD_MAX,
            FIELD_MIN, 65535), '0}};
        rows = {rows, row_t'{ROW_PREDICT,
            mk_pair(-5, 7, 1, 2, 1, 5, -7, 3, 4, 65535), '0}};
        rows = {rows, row_t'{ROW_PREDICT, mk_pair(100, 100, -9000, 7000, 300, -50, 200,
            8000, -6000, 20), '0}};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            unique case (row.kind)
                ROW_UNCHANGED:
                begin
                    o.a = row.pair.a;
                    o.b = row.pair.b;
                    o.hit = 1'b0;
                end
                ROW_TYPED:
                    o = row.typed;
                default:
                    o = resolve_pair(row.pair);
            endcase
            transfer_pair(row.pair, o, 1'b1);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            row.pair = rand_pair();
            transfer_pair(row.pair, resolve_pair(row.pair), n < NUM_RANDOM - QUIET_ITEMS);
        end
        start <= 1'b0;

        while (resolved_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("circle_pair_elastic_collision_unit test passed");
        else
            $display("circle_pair_elastic_collision_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cpec_pkg.sv
rtl/core/cpec_isqrt.sv
rtl/core/cpec_rdiv.sv
rtl/core/circle_pair_elastic_collision_unit.sv
tb/testbench.sv
